// ===== sv/dhfk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhfk_pkg
// shared types, link constants and rounding helpers for the six-joint
// denavit-hartenberg forward kinematics pipeline
// ----------------------------------------------------------------------------
package dhfk_pkg;

	localparam int IN_W  = 112;
	localparam int OUT_W = 224;
	localparam int ANG_W = 18;
	localparam int NJ    = 6;
	localparam int LAT   = 30;

	typedef logic signed [31:0] q28_t;

	typedef struct packed {
		q28_t sn;
		q28_t cs;
		q28_t ax;
		q28_t ay;
	} jd_t;

	typedef enum logic [1:0] {
		TW_UP   = 2'd0,
		TW_DOWN = 2'd1,
		TW_FLAT = 2'd2
	} twist_t;

	localparam logic [28:0] Q_ONE     = 29'd268435456;
	localparam logic [34:0] HALF_PI   = 35'd421657428;
	localparam logic [34:0] HALF_PI_H = 35'd210828714;
	localparam logic [34:0] X_BIAS    = 35'd3373259424;

	localparam logic [28:0] RCP_SIN [4] = '{29'd477218589, 29'd409044505,
		29'd429496730, 29'd357913942};
	localparam int SH_SIN [4] = '{35, 34, 33, 31};
	localparam logic [28:0] RCP_COS [5] = '{29'd381774871, 29'd306783379,
		29'd286331154, 29'd357913942, 29'd268435456};
	localparam int SH_COS [5] = '{35, 34, 33, 32, 29};

	localparam q28_t LINK_D [NJ] = '{32'sd43620762, 32'sd0, 32'sd0,
		32'sd35782446, 32'sd26763015, 32'sd26736171};
	localparam q28_t LINK_A [NJ] = '{32'sd0, -32'sd114085069, -32'sd105280386,
		32'sd0, 32'sd0, 32'sd0};
	localparam twist_t TWIST [NJ] = '{TW_UP, TW_FLAT, TW_FLAT, TW_UP, TW_DOWN, TW_FLAT};

	localparam q28_t IDENT [3][4] = '{
		'{32'sd268435456, 32'sd0, 32'sd0, 32'sd0},
		'{32'sd0, 32'sd268435456, 32'sd0, 32'sd0},
		'{32'sd0, 32'sd0, 32'sd268435456, 32'sd0}};

	// round to nearest by 2^28, ties away from zero
	function automatic logic signed [63:0] round_q28(input logic signed [63:0] v);
		logic [63:0] mag;
		mag = v[63] ? (64'd0 - v) : v;
		mag = (mag + 64'd134217728) >> 28;
		return v[63] ? -$signed(mag) : $signed(mag);
	endfunction

	// round to nearest by 2^12, ties away from zero
	function automatic logic signed [20:0] round_q12(input q28_t v);
		logic [31:0] mag;
		mag = v[31] ? (32'd0 - v) : v;
		mag = (mag + 32'd2048) >> 12;
		return v[31] ? -$signed({1'b0, mag[19:0]}) : $signed({1'b0, mag[19:0]});
	endfunction

endpackage

// ===== sv/dhfk_trig.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhfk_trig
// pipelined sine and cosine of one joint angle: quadrant reduction, then
// horner evaluation of both series side by side, fifteen stages
// ----------------------------------------------------------------------------
module dhfk_trig (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [17:0]         ang,
	output dhfk_pkg::q28_t             sn,
	output dhfk_pkg::q28_t             cs
);
	import dhfk_pkg::*;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	logic [32:0]        x_s1;
	logic [1:0]         q_s2, q_s3, q_s4;
	logic signed [28:0] r_s2, r_s3, r_s4;
	logic [57:0]        rr_s3;
	logic [27:0]        r2_s4;

	// slot i: stage a is 5+2i, stage b is 6+2i
	logic [27:0]        r2_sa [5];
	logic [27:0]        r2_sb [4];
	logic signed [28:0] r_sa [4];
	logic signed [28:0] r_sb [4];
	logic [1:0]         q_sa [5];
	logic [1:0]         q_sb [5];
	logic [56:0]        cprd_sa [5];
	logic [27:0]        cquo_sb [5];
	logic [56:0]        sprd_sa [4];
	logic [27:0]        squo_sb [4];
	logic signed [58:0] sfin_sa;
	q28_t               sin_sb;

	logic [34:0] xw;
	logic [3:0]  qn;
	logic [34:0] thr;
	logic [34:0] rdiff;
	logic signed [57:0] rr_full;
	logic [57:0] rr_rnd;

	always_comb begin
		xw = {{3{ang[17]}}, ang, 14'd0} + X_BIAS;
	end

	always_comb begin
		qn = 4'd0;
		thr = '0;
		for (int k = 1; k < 16; k++) begin
			thr = 35'(k) * HALF_PI - HALF_PI_H;
			if ({2'b00, x_s1} >= thr) begin
				qn = 4'(k);
			end
		end
		rdiff = {2'b00, x_s1} - 35'(qn) * HALF_PI;
	end

	assign rr_full = r_s2 * r_s2;
	assign rr_rnd = rr_s3 + 58'd134217728;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= xw[32:0];
			q_s2  <= qn[1:0];
			r_s2  <= $signed(rdiff[28:0]);
			q_s3  <= q_s2;
			r_s3  <= r_s2;
			rr_s3 <= $unsigned(rr_full);
			q_s4  <= q_s3;
			r_s4  <= r_s3;
			r2_s4 <= rr_rnd[55:28];
		end
	end

	for (genvar i = 0; i < 5; i++) begin : g_slot
		logic [27:0]        r2_in;
		logic signed [28:0] r_in;
		logic [1:0]         q_in;
		logic [28:0]        tc_in, ts_in;
		logic [27:0]        cv;
		logic [56:0]        cm, csh;

		if (i == 0) begin : g_first
			assign r2_in = r2_s4;
			assign r_in  = r_s4;
			assign q_in  = q_s4;
			assign tc_in = Q_ONE;
			assign ts_in = Q_ONE;
		end else begin : g_next
			assign r2_in = r2_sb[i-1];
			assign r_in  = r_sb[i-1];
			assign q_in  = q_sb[i-1];
			assign tc_in = Q_ONE - {1'b0, cquo_sb[i-1]};
			assign ts_in = Q_ONE - {1'b0, squo_sb[i-1]};
		end

		always_comb begin
			cv  = 28'(cprd_sa[i][56:28] + 29'(cprd_sa[i][27]));
			cm  = cv * RCP_COS[i];
			csh = cm >> SH_COS[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r2_sa[i]   <= r2_in;
				q_sa[i]    <= q_in;
				cprd_sa[i] <= r2_in * tc_in;
				q_sb[i]    <= q_sa[i];
				cquo_sb[i] <= csh[27:0];
			end
		end

		if (i < 4) begin : g_sin
			logic [27:0] sv;
			logic [56:0] sm, ssh;

			always_comb begin
				sv  = 28'(sprd_sa[i][56:28] + 29'(sprd_sa[i][27]));
				sm  = sv * RCP_SIN[i];
				ssh = sm >> SH_SIN[i];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					r_sa[i]    <= r_in;
					sprd_sa[i] <= r2_in * ts_in;
					r2_sb[i]   <= r2_sa[i];
					r_sb[i]    <= r_sa[i];
					squo_sb[i] <= ssh[27:0];
				end
			end
		end else begin : g_sfin
			always_ff @(posedge clk) begin
				if (en) begin
					sfin_sa <= r_in * $signed({1'b0, ts_in});
					sin_sb  <= q28_t'(round_q28(64'(sfin_sa)));
				end
			end
		end
	end

	logic [28:0] cf;
	q28_t        cval, sn_n, cs_n;

	always_comb begin
		cf   = Q_ONE - {1'b0, cquo_sb[4]};
		cval = q28_t'({3'b000, cf});
		unique case (q_sb[4])
			QUAD_0: begin
				sn_n = sin_sb;
				cs_n = cval;
			end
			QUAD_1: begin
				sn_n = cval;
				cs_n = -sin_sb;
			end
			QUAD_2: begin
				sn_n = -sin_sb;
				cs_n = -cval;
			end
			QUAD_3: begin
				sn_n = -cval;
				cs_n = sin_sb;
			end
			default: begin
				sn_n = sin_sb;
				cs_n = cval;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn <= sn_n;
			cs <= cs_n;
		end
	end

endmodule

// ===== sv/dh_forward_kinematics_six_joint.sv =====
`timescale 1ns / 1ps
// throughput: one joint vector per cycle while not stalled, set by the fully
//   pipelined trig lanes and the two-stage matrix step per joint
// a stall on m_tready freezes every stage at once; nothing is dropped
// reset: arst_n clears all valid bits asynchronously; data is not reset
// ----------------------------------------------------------------------------
// dh_forward_kinematics_six_joint
// six-joint dh forward kinematics: six parallel sine/cosine lanes, then a
// chain of six 3x4 transform products, then rounding and saturation
// ----------------------------------------------------------------------------
module dh_forward_kinematics_six_joint (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// joint_angle_1 .. joint_angle_6, 18 bits each, then zero pad
	input  logic [dhfk_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// position_x, position_y, position_z (20 bits each),
	// rot_00 .. rot_22 (18 bits each, row major), then zero pad
	output logic [dhfk_pkg::OUT_W-1:0]   m_tdata
);
	import dhfk_pkg::*;

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	q28_t               sn_s15 [NJ];
	q28_t               cs_s15 [NJ];
	q28_t               sn_s16 [NJ];
	q28_t               cs_s16 [NJ];
	logic signed [63:0] pa_s16 [NJ];
	logic signed [63:0] pb_s16 [NJ];
	jd_t                jd_s17 [NJ];
	jd_t                jd_use [NJ];

	for (genvar j = 0; j < NJ; j++) begin : g_joint
		dhfk_trig u_trig (
			.clk (clk),
			.en  (en),
			.ang ($signed(s_tdata[ANG_W*j +: ANG_W])),
			.sn  (sn_s15[j]),
			.cs  (cs_s15[j])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				sn_s16[j]    <= sn_s15[j];
				cs_s16[j]    <= cs_s15[j];
				pa_s16[j]    <= LINK_A[j] * cs_s15[j];
				pb_s16[j]    <= LINK_A[j] * sn_s15[j];
				jd_s17[j].sn <= sn_s16[j];
				jd_s17[j].cs <= cs_s16[j];
				jd_s17[j].ax <= q28_t'(round_q28(pa_s16[j]));
				jd_s17[j].ay <= q28_t'(round_q28(pb_s16[j]));
			end
		end

		if (j == 0) begin : g_nodly
			assign jd_use[j] = jd_s17[j];
		end else begin : g_dly
			jd_t dly_q [2*j];
			always_ff @(posedge clk) begin
				if (en) begin
					dly_q[0] <= jd_s17[j];
					for (int n = 1; n < 2*j; n++) begin
						dly_q[n] <= dly_q[n-1];
					end
				end
			end
			assign jd_use[j] = dly_q[2*j-1];
		end
	end

	// joint j: products at stage 18+2j, sums at stage 19+2j
	logic signed [63:0] pr_sa [NJ][3][7];
	q28_t               mr2_sa [NJ][3];
	q28_t               mr3_sa [NJ][3];
	q28_t               m_sb [NJ][3][4];

	for (genvar j = 0; j < NJ; j++) begin : g_step
		q28_t m_in [3][4];

		for (genvar r = 0; r < 3; r++) begin : g_row
			for (genvar c = 0; c < 4; c++) begin : g_col
				if (j == 0) begin : g_id
					assign m_in[r][c] = IDENT[r][c];
				end else begin : g_prev
					assign m_in[r][c] = m_sb[j-1][r][c];
				end
			end

			logic signed [63:0] col0, e, col3;

			always_comb begin
				col0 = round_q28(pr_sa[j][r][0] + pr_sa[j][r][1]);
				e    = round_q28(pr_sa[j][r][2] - pr_sa[j][r][3]);
				col3 = round_q28((64'(mr3_sa[j][r]) <<< 28) + pr_sa[j][r][4]
					+ pr_sa[j][r][5] + pr_sa[j][r][6]);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					pr_sa[j][r][0] <= m_in[r][0] * jd_use[j].cs;
					pr_sa[j][r][1] <= m_in[r][1] * jd_use[j].sn;
					pr_sa[j][r][2] <= m_in[r][0] * jd_use[j].sn;
					pr_sa[j][r][3] <= m_in[r][1] * jd_use[j].cs;
					pr_sa[j][r][4] <= m_in[r][0] * jd_use[j].ax;
					pr_sa[j][r][5] <= m_in[r][1] * jd_use[j].ay;
					pr_sa[j][r][6] <= m_in[r][2] * LINK_D[j];
					mr2_sa[j][r]   <= m_in[r][2];
					mr3_sa[j][r]   <= m_in[r][3];
					m_sb[j][r][0]  <= q28_t'(col0);
					m_sb[j][r][3]  <= q28_t'(col3);
					unique case (TWIST[j])
						TW_UP: begin
							m_sb[j][r][1] <= mr2_sa[j][r];
							m_sb[j][r][2] <= q28_t'(e);
						end
						TW_DOWN: begin
							m_sb[j][r][1] <= -mr2_sa[j][r];
							m_sb[j][r][2] <= -q28_t'(e);
						end
						TW_FLAT: begin
							m_sb[j][r][1] <= -q28_t'(e);
							m_sb[j][r][2] <= mr2_sa[j][r];
						end
						default: begin
							m_sb[j][r][1] <= mr2_sa[j][r];
							m_sb[j][r][2] <= q28_t'(e);
						end
					endcase
				end
			end
		end
	end

	logic signed [19:0] pos_s30 [3];
	logic signed [17:0] rot_s30 [3][3];

	for (genvar r = 0; r < 3; r++) begin : g_out
		logic signed [20:0] pv;
		logic signed [20:0] rv [3];
		logic signed [19:0] pc;
		logic signed [17:0] rc [3];

		always_comb begin
			pv = round_q12(m_sb[NJ-1][r][3]);
			if (pv > 21'sd524287) begin
				pc = 20'sd524287;
			end else if (pv < -21'sd524288) begin
				pc = -20'sd524288;
			end else begin
				pc = pv[19:0];
			end
			for (int c = 0; c < 3; c++) begin
				rv[c] = round_q12(m_sb[NJ-1][r][c]);
				if (rv[c] > 21'sd65536) begin
					rc[c] = 18'sd65536;
				end else if (rv[c] < -21'sd65536) begin
					rc[c] = -18'sd65536;
				end else begin
					rc[c] = rv[c][17:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pos_s30[r] <= pc;
				for (int c = 0; c < 3; c++) begin
					rot_s30[r][c] <= rc[c];
				end
			end
		end
	end

	logic rot_ok;

	always_comb begin
		m_tdata = '0;
		rot_ok  = 1'b1;
		for (int r = 0; r < 3; r++) begin
			m_tdata[20*r +: 20] = pos_s30[r];
			for (int c = 0; c < 3; c++) begin
				m_tdata[60 + 18*(3*r+c) +: 18] = rot_s30[r][c];
				if (rot_s30[r][c] > 18'sd65536 || rot_s30[r][c] < -18'sd65536) begin
					rot_ok = 1'b0;
				end
			end
		end
	end

	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> rot_ok)
		else $error("rotation entry out of range");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> vld_q == $past(vld_q))
		else $error("pipeline moved while stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted transfer not in first stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !vld_q[LAT-2] |=> !m_tvalid)
		else $error("output transfer repeated");

endmodule
